// ===== rtl/coapb2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CoAP Block2 download controller package
// Shared beat types, phase codes, error codes and protocol constants.
// ----------------------------------------------------------------------------
package coapb2_pkg;

   // Width of the stored block number; the result field is always 20 bits.
   localparam int BLOCK_NUM_BITS = 20;
   localparam int REQ_BLOCK_BITS = 20;

   // Phase codes.
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_SEND = 3'd1;
   localparam logic [2:0] PH_RECV = 3'd2;
   localparam logic [2:0] PH_ERR  = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   // Event kinds.
   localparam logic [1:0] KIND_STEP  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   // Request building status.
   localparam logic [1:0] SEND_OK        = 2'd0;
   localparam logic [1:0] SEND_OPT_FAIL  = 2'd1;
   localparam logic [1:0] SEND_SER_FAIL  = 2'd2;
   localparam logic [1:0] SEND_XMIT_FAIL = 2'd3;

   // Receive status.
   localparam logic [1:0] RECV_NONE       = 2'd0;
   localparam logic [1:0] RECV_PARSED     = 2'd1;
   localparam logic [1:0] RECV_FAIL       = 2'd2;
   localparam logic [1:0] RECV_PARSE_FAIL = 2'd3;

   // Error codes.
   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_OPTION   = 4'd1;
   localparam logic [3:0] ERR_SERIAL   = 4'd2;
   localparam logic [3:0] ERR_SEND     = 4'd3;
   localparam logic [3:0] ERR_TIMEOUT  = 4'd4;
   localparam logic [3:0] ERR_RECEIVE  = 4'd5;
   localparam logic [3:0] ERR_PARSE    = 4'd6;
   localparam logic [3:0] ERR_NOTFOUND = 4'd7;
   localparam logic [3:0] ERR_SERVER   = 4'd8;
   localparam logic [3:0] ERR_BLOCK    = 4'd9;

   // Message constants.
   localparam logic [7:0] CODE_CONTENT   = 8'd69;
   localparam logic [7:0] CODE_NOT_FOUND = 8'd132;
   localparam logic [1:0] TYPE_ACK       = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_MAX_ATTEMPTS = 1'b0;
   localparam logic CSR_TIMEOUT      = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd4;
   localparam logic [7:0] TIMEOUT_RST      = 8'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  send_status;
      logic [1:0]  receive_status;
      logic [1:0]  msg_type;
      logic [15:0] msg_id;
      logic [7:0]  msg_code;
      logic        block_ok;
      logic        more_blocks;
      logic [15:0] fresh_mid;
   } req_type;

   typedef struct packed {
      logic [2:0]                phase;
      logic                      request_valid;
      logic [15:0]               request_mid;
      logic [REQ_BLOCK_BITS-1:0] request_block;
      logic                      store_chunk;
      logic [3:0]                error_code;
      logic [7:0]                wait_seconds;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/coap_block2_download_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CoAP Block2 download controller
// Sequences a block-wise download over confirmable GET requests.
// ----------------------------------------------------------------------------
// Each request beat carries one event (step, start or stop) and produces
// exactly one response beat. A beat is captured in an input register, run
// through the phase handler, and lands in a result register; one beat is
// taken every cycle when the response side does not stall. The update of
// the phase, message id, block number and retry count as each beat lands
// in the result register is what sets that rate.
// Configuration writes take effect at once and belong between downloads.
module coap_block2_download_controller (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire coapb2_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output coapb2_pkg::rsp_type    rsp_data,
   input  wire                    csr_we,
   input  wire                    csr_index,
   input  wire [7:0]              csr_wdata
);
   import coapb2_pkg::*;

   // Configuration registers.
   logic [3:0] max_attempts_ff;
   logic [7:0] timeout_ff;

   // Input and result stages.
   logic    in_valid_ff;
   req_type in_ff;
   logic    out_valid_ff;
   rsp_type out_ff;
   rsp_type out_in;
   logic    out_free;
   logic    advance;

   // Controller state.
   logic [2:0]                phase_now_ff, phase_now_in;
   logic [2:0]                phase_next_ff, phase_next_in;
   logic [15:0]               mid_ff, mid_in;
   logic [3:0]                attempt_ff, attempt_in;
   logic [BLOCK_NUM_BITS-1:0] block_ff, block_in;
   logic [3:0]                error_ff, error_in;
   logic [4:0]                attempt_inc;
   logic                      retry;
   logic [15:0]               mid_fixed;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= MAX_ATTEMPTS_RST;
         timeout_ff      <= TIMEOUT_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_MAX_ATTEMPTS) begin
            max_attempts_ff <= csr_wdata[3:0];
         end else begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // Stage flow: the input beat moves on whenever the result slot is free.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= advance;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   // Retry count and the message id once it has been fixed for a send.
   assign attempt_inc = {1'b0, attempt_ff} + 5'd1;
   assign mid_fixed   = (mid_ff == 16'd0) ? in_ff.fresh_mid : mid_ff;

   // Phase handler for the beat in the input register.
   always_comb begin
      phase_now_in  = phase_now_ff;
      phase_next_in = phase_next_ff;
      mid_in        = mid_ff;
      attempt_in    = attempt_ff;
      block_in      = block_ff;
      error_in      = error_ff;
      retry         = 1'b0;
      out_in        = '0;

      if (in_ff.kind == KIND_START) begin
         phase_next_in = PH_SEND;
      end else if (in_ff.kind == KIND_STOP) begin
         phase_next_in = PH_ERR;
      end else if (in_ff.kind == KIND_STEP) begin
         unique case (phase_next_ff)
            PH_IDLE: begin
               phase_now_in  = PH_IDLE;
               phase_next_in = PH_IDLE;
            end
            PH_SEND: begin
               phase_now_in = PH_SEND;
               if (in_ff.send_status == SEND_OPT_FAIL) begin
                  error_in      = ERR_OPTION;
                  phase_next_in = PH_ERR;
               end else begin
                  mid_in = mid_fixed;
                  if (in_ff.send_status == SEND_SER_FAIL) begin
                     error_in      = ERR_SERIAL;
                     phase_next_in = PH_ERR;
                  end else if (in_ff.send_status == SEND_XMIT_FAIL) begin
                     error_in      = ERR_SEND;
                     phase_next_in = PH_ERR;
                  end else begin
                     out_in.request_valid = 1'b1;
                     out_in.request_mid   = mid_fixed;
                     out_in.request_block = REQ_BLOCK_BITS'(block_ff);
                     out_in.wait_seconds  = timeout_ff;
                     phase_next_in        = PH_RECV;
                  end
               end
            end
            PH_RECV: begin
               phase_now_in = PH_RECV;
               if (in_ff.receive_status == RECV_NONE) begin
                  retry = 1'b1;
               end else if (in_ff.receive_status == RECV_FAIL) begin
                  error_in      = ERR_RECEIVE;
                  phase_next_in = PH_ERR;
               end else if (in_ff.receive_status == RECV_PARSE_FAIL) begin
                  error_in      = ERR_PARSE;
                  phase_next_in = PH_ERR;
               end else if (in_ff.msg_type != TYPE_ACK || in_ff.msg_id != mid_ff) begin
                  retry = 1'b1;
               end else if (in_ff.msg_code == CODE_NOT_FOUND) begin
                  error_in      = ERR_NOTFOUND;
                  phase_next_in = PH_ERR;
               end else if (in_ff.msg_code != CODE_CONTENT) begin
                  error_in      = ERR_SERVER;
                  phase_next_in = PH_ERR;
               end else if (!in_ff.block_ok) begin
                  error_in      = ERR_BLOCK;
                  phase_next_in = PH_ERR;
               end else begin
                  out_in.store_chunk = 1'b1;
                  attempt_in         = 4'd0;
                  if (in_ff.more_blocks) begin
                     block_in      = block_ff + BLOCK_NUM_BITS'(1);
                     mid_in        = in_ff.msg_id + 16'd1;
                     phase_next_in = PH_SEND;
                  end else begin
                     phase_next_in = PH_DONE;
                  end
               end

               // Missing or mismatched response: resend or give up.
               if (retry) begin
                  if (attempt_inc > {1'b0, max_attempts_ff}) begin
                     attempt_in    = 4'd0;
                     error_in      = ERR_TIMEOUT;
                     phase_next_in = PH_ERR;
                  end else begin
                     attempt_in    = attempt_inc[3:0];
                     phase_next_in = PH_SEND;
                  end
               end
            end
            PH_ERR: begin
               phase_now_in  = PH_ERR;
               phase_next_in = PH_IDLE;
            end
            PH_DONE: begin
               phase_now_in  = PH_DONE;
               phase_next_in = PH_IDLE;
            end
            default: begin
               phase_next_in = PH_ERR;
            end
         endcase
      end

      out_in.phase      = phase_now_in;
      out_in.error_code = error_in;
   end

   // State update as each beat passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_now_ff  <= PH_IDLE;
         phase_next_ff <= PH_IDLE;
         mid_ff        <= 16'd0;
         attempt_ff    <= 4'd0;
         block_ff      <= '0;
         error_ff      <= ERR_NONE;
      end else if (advance) begin
         phase_now_ff  <= phase_now_in;
         phase_next_ff <= phase_next_in;
         mid_ff        <= mid_in;
         attempt_ff    <= attempt_in;
         block_ff      <= block_in;
         error_ff      <= error_in;
      end
   end

endmodule
`default_nettype wire
